// ----- rtl/mp2d_pkg.sv -----
package mp2d_pkg;

	localparam int NUM_REGS   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIM_W      = 11;
	localparam int WIN_W      = 4;
	localparam int PLANES_W   = 16;
	localparam int OUT_POS_W  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COL_STEP      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT   = 3'd6;

	typedef struct packed {
		logic [DIM_W-1:0]    plane_height;
		logic [DIM_W-1:0]    plane_width;
		logic [WIN_W-1:0]    window_height;
		logic [WIN_W-1:0]    window_width;
		logic [WIN_W-1:0]    row_step;
		logic [WIN_W-1:0]    col_step;
		logic [PLANES_W-1:0] plane_count;
	} cfg_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] out_row;
		logic [OUT_POS_W-1:0] out_col;
		logic                 plane_last;
		logic                 batch_last;
	} res_tag_t;

endpackage

// ----- rtl/mp2d_if.sv -----
interface mp2d_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mp2d_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic [9:0]                    out_row;
	logic [9:0]                    out_col;
	logic                          plane_last;
	logic                          batch_last;

	modport source (output valid, output max_value, output out_row, output out_col,
		output plane_last, output batch_last, input ready);
	modport sink (input valid, input max_value, input out_row, input out_col,
		input plane_last, input batch_last, output ready);
endinterface

// ----- rtl/mp2d_ram.sv -----
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/mp2d_cmdq.sv -----
module mp2d_cmdq #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

// ----- rtl/mp2d_front.sv -----
module mp2d_front import mp2d_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_KERNEL  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int PW = CW + 1,
	localparam int KW = $clog2(MAX_KERNEL + 1),
	localparam int SW = $clog2(MAX_KERNEL)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   restart,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output logic                   wr_en,
	output logic [SW-1:0]          wr_bank,
	output logic [CW-1:0]          wr_addr,
	output logic [SAMPLE_BITS-1:0] wr_data,
	input  logic                   q_full,
	input  logic                   q_empty,
	input  logic                   back_busy,
	output logic                   cmd_push,
	output logic [MAX_KERNEL-1:0]  cmd_mask,
	output logic [CW-1:0]          cmd_left,
	output logic [KW-1:0]          cmd_kw,
	output res_tag_t               cmd_tag
);
	logic [CW-1:0]       row_q, col_q;
	logic [SW-1:0]       slot_q;
	logic [PLANES_W-1:0] plane_q;
	logic [PW:0]         win_top_q, win_left_q;
	logic [CW-1:0]       orow_q, ocol_q;
	logic                safe_q;

	logic [PW-1:0]       h, w, r1, c1;
	logic [KW-1:0]       kh, kw;
	logic [WIN_W-1:0]    sh, sw;
	logic [PLANES_W-1:0] np;
	logic [PW:0]         top, left;
	logic                row_hit, col_hit, wrap_col, wrap_row, accept, plast;
	logic [SW:0]         top_slot;

	always_comb begin
		h = (cfg.plane_height == '0) ? PW'(1) :
			(32'(cfg.plane_height) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(cfg.plane_height);
		w = (cfg.plane_width == '0) ? PW'(1) :
			(32'(cfg.plane_width) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(cfg.plane_width);
		kh = (cfg.window_height == '0) ? KW'(1) :
			(32'(cfg.window_height) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg.window_height);
		kw = (cfg.window_width == '0) ? KW'(1) :
			(32'(cfg.window_width) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg.window_width);
		sh = (cfg.row_step == '0) ? WIN_W'(1) : cfg.row_step;
		sw = (cfg.col_step == '0) ? WIN_W'(1) : cfg.col_step;
		np = (cfg.plane_count == '0) ? PLANES_W'(1) : cfg.plane_count;
	end

	assign r1       = PW'(row_q) + PW'(1);
	assign c1       = PW'(col_q) + PW'(1);
	assign top      = (PW+1)'(r1) - (PW+1)'(kh);
	assign left     = (PW+1)'(c1) - (PW+1)'(kw);
	assign row_hit  = ((PW+1)'(r1) >= (PW+1)'(kh)) && (top == win_top_q);
	assign col_hit  = ((PW+1)'(c1) >= (PW+1)'(kw)) && (left == win_left_q);
	assign wrap_col = (c1 >= w);
	assign wrap_row = (r1 >= h);
	assign plast    = ((PW+1)'(r1) + (PW+1)'(sh) > (PW+1)'(h))
		&& ((PW+1)'(c1) + (PW+1)'(sw) > (PW+1)'(w));

	// earlier windows still pending: only writes further along the same row are safe
	assign in_ready = !q_full && ((q_empty && !back_busy) || safe_q);
	assign accept   = in_valid && in_ready;

	assign wr_en   = accept;
	assign wr_bank = slot_q;
	assign wr_addr = col_q;
	assign wr_data = in_sample;

	always_comb begin
		top_slot = (SW+1)'(slot_q) + (SW+1)'(1) - (SW+1)'(kh);
		if (32'(slot_q) + 1 < 32'(kh)) begin
			top_slot = (SW+1)'(32'(slot_q) + 1 + MAX_KERNEL - 32'(kh));
		end
		for (int b = 0; b < MAX_KERNEL; b++) begin
			if (b >= 32'(top_slot)) begin
				cmd_mask[b] = (b - 32'(top_slot)) < 32'(kh);
			end else begin
				cmd_mask[b] = (b + MAX_KERNEL - 32'(top_slot)) < 32'(kh);
			end
		end
	end

	assign cmd_push           = accept && row_hit && col_hit;
	assign cmd_left           = CW'(left);
	assign cmd_kw             = kw;
	assign cmd_tag.out_row    = OUT_POS_W'(orow_q);
	assign cmd_tag.out_col    = OUT_POS_W'(ocol_q);
	assign cmd_tag.plane_last = plast;
	assign cmd_tag.batch_last = plast && ((PLANES_W+1)'(plane_q) + (PLANES_W+1)'(1)
		>= (PLANES_W+1)'(np));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= '0;
			plane_q    <= '0;
			win_top_q  <= '0;
			win_left_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			safe_q     <= 1'b0;
		end else if (restart) begin
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= '0;
			plane_q    <= '0;
			win_top_q  <= '0;
			win_left_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			safe_q     <= 1'b0;
		end else if (accept) begin
			safe_q <= !wrap_col;
			if (wrap_col) begin
				col_q      <= '0;
				win_left_q <= '0;
				ocol_q     <= '0;
				if (wrap_row) begin
					row_q     <= '0;
					slot_q    <= '0;
					win_top_q <= '0;
					orow_q    <= '0;
					if ((PLANES_W+1)'(plane_q) + (PLANES_W+1)'(1) >= (PLANES_W+1)'(np)) begin
						plane_q <= '0;
					end else begin
						plane_q <= plane_q + PLANES_W'(1);
					end
				end else begin
					row_q  <= CW'(r1);
					slot_q <= (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + SW'(1);
					if (row_hit) begin
						win_top_q <= win_top_q + (PW+1)'(sh);
						orow_q    <= orow_q + CW'(1);
					end
				end
			end else begin
				col_q <= CW'(c1);
				if (col_hit) begin
					win_left_q <= win_left_q + (PW+1)'(sw);
					ocol_q     <= ocol_q + CW'(1);
				end
			end
		end
	end
endmodule

// ----- rtl/mp2d_back.sv -----
module mp2d_back import mp2d_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_KERNEL  = 8,
	parameter int SAMPLE_BITS = 16,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int KW = $clog2(MAX_KERNEL + 1)
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_empty,
	output logic                                    q_pop,
	input  logic [MAX_KERNEL-1:0]                   cmd_mask,
	input  logic [CW-1:0]                           cmd_left,
	input  logic [KW-1:0]                           cmd_kw,
	input  res_tag_t                                cmd_tag,
	output logic [CW-1:0]                           rd_addr,
	input  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]  rd_data,
	output logic                                    busy,
	mp2d_out_if.source                              results
);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]                    state_q;
	logic [MAX_KERNEL-1:0]         mask_q;
	logic [CW-1:0]                 left_q;
	logic [KW-1:0]                 kw_q, col_q;
	res_tag_t                      tag_q;
	logic                          vld_s1, last_s1, first_s1;
	logic signed [SAMPLE_BITS-1:0] best_q, col_max, fold;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	res_tag_t                      out_tag_q;
	logic                          out_free;

	assign busy     = (state_q != ST_IDLE);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign rd_addr  = left_q + CW'(col_q);
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		col_max = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		for (int b = 0; b < MAX_KERNEL; b++) begin
			if (mask_q[b] && ($signed(rd_data[b]) > col_max)) begin
				col_max = $signed(rd_data[b]);
			end
		end
		fold = (first_s1 || col_max > best_q) ? col_max : best_q;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mask_q <= cmd_mask;
			left_q <= cmd_left;
			kw_q   <= cmd_kw;
			tag_q  <= cmd_tag;
		end
		if (vld_s1) begin
			best_q <= fold;
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_value_q <= best_q;
			out_tag_q   <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1   <= (state_q == ST_READ);
			last_s1  <= (state_q == ST_READ) && (col_q + KW'(1) == kw_q);
			first_s1 <= (state_q == ST_READ) && (col_q == '0);
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					col_q <= '0;
					if (!q_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					col_q <= col_q + KW'(1);
					if (col_q + KW'(1) == kw_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s1 && last_s1) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid      = out_valid_q;
	assign results.max_value  = out_value_q;
	assign results.out_row    = out_tag_q.out_row;
	assign results.out_col    = out_tag_q.out_col;
	assign results.plane_last = out_tag_q.plane_last;
	assign results.batch_last = out_tag_q.batch_last;
endmodule

// ----- rtl/max_pool_2d_stream.sv -----
// channel   dir  payload
// samples   in   sample
// results   out  max_value, out_row, out_col, plane_last, batch_last
// config    in   cfg_we, cfg_index, cfg_data
//
// an accepted sample is written to its line bank at once
// in the back unit a window is read one column per cycle from all banks in
// parallel, then passes the fold and the output register
// windows queue two deep; a sample of a new row waits until pending windows finish
// reset clears positions and control, line banks are never cleared
module max_pool_2d_stream import mp2d_pkg::*; #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_KERNEL  = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mp2d_in_if.sink               samples,
	mp2d_out_if.source            results
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int SW = $clog2(MAX_KERNEL);
	localparam int QW = MAX_KERNEL + CW + KW + $bits(res_tag_t);

	cfg_t                                  cfg_q;
	logic                                  restart;
	logic                                  wr_en;
	logic [SW-1:0]                         wr_bank;
	logic [CW-1:0]                         wr_addr, rd_addr;
	logic [SAMPLE_BITS-1:0]                wr_data;
	logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] rd_data;
	logic                                  q_full, q_empty, q_pop, push, back_busy;
	logic [MAX_KERNEL-1:0]                 f_mask, b_mask;
	logic [CW-1:0]                         f_left, b_left;
	logic [KW-1:0]                         f_kw, b_kw;
	res_tag_t                              f_tag, b_tag;

	always_comb begin
		case (cfg_index)
			REG_PLANE_HEIGHT, REG_PLANE_WIDTH, REG_WINDOW_HEIGHT, REG_WINDOW_WIDTH,
			REG_ROW_STEP, REG_COL_STEP, REG_PLANE_COUNT: restart = cfg_we;
			default: restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_height  <= DIM_W'(1);
			cfg_q.plane_width   <= DIM_W'(1);
			cfg_q.window_height <= WIN_W'(1);
			cfg_q.window_width  <= WIN_W'(1);
			cfg_q.row_step      <= WIN_W'(1);
			cfg_q.col_step      <= WIN_W'(1);
			cfg_q.plane_count   <= PLANES_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_HEIGHT:  cfg_q.plane_height  <= cfg_data[DIM_W-1:0];
				REG_PLANE_WIDTH:   cfg_q.plane_width   <= cfg_data[DIM_W-1:0];
				REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data[WIN_W-1:0];
				REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data[WIN_W-1:0];
				REG_ROW_STEP:      cfg_q.row_step      <= cfg_data[WIN_W-1:0];
				REG_COL_STEP:      cfg_q.col_step      <= cfg_data[WIN_W-1:0];
				REG_PLANE_COUNT:   cfg_q.plane_count   <= cfg_data[PLANES_W-1:0];
				default: ;
			endcase
		end
	end

	mp2d_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .restart(restart),
		.in_valid(samples.valid), .in_ready(samples.ready), .in_sample(samples.sample),
		.wr_en(wr_en), .wr_bank(wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
		.q_full(q_full), .q_empty(q_empty), .back_busy(back_busy),
		.cmd_push(push), .cmd_mask(f_mask), .cmd_left(f_left), .cmd_kw(f_kw),
		.cmd_tag(f_tag)
	);

	mp2d_cmdq #(.WIDTH(QW)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata({f_mask, f_left, f_kw, f_tag}),
		.pop(q_pop), .rdata({b_mask, b_left, b_kw, b_tag}), .empty(q_empty), .full(q_full)
	);

	for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
		mp2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_ram (
			.clk(clk), .we(wr_en && (32'(wr_bank) == b)), .waddr(wr_addr),
			.wdata(wr_data), .raddr(rd_addr), .rdata(rd_data[b])
		);
	end

	mp2d_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_pop(q_pop),
		.cmd_mask(b_mask), .cmd_left(b_left), .cmd_kw(b_kw), .cmd_tag(b_tag),
		.rd_addr(rd_addr), .rd_data(rd_data), .busy(back_busy), .results(results)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("window queue overflow");

	a_batch_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.batch_last || results.plane_last))
		else $error("batch end without plane end");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> back_busy)
		else $error("window popped but back unit idle");
endmodule
